FILE: rtl/core/xmr_pkg.sv
// ----------------------------------------------------------------------------
// xmr_pkg
// Types and constants shared by the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
package xmr_pkg;

  localparam int BLOCK_BYTES = 128;
  // frame position runs from 0 to BLOCK_BYTES + 3 (SOH, block, complement,
  // data bytes, checksum)
  localparam int FP_W = $clog2(BLOCK_BYTES + 4);
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [1:0] CFG_BASE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_START_WINDOW  = 2'd1;
  localparam logic [1:0] CFG_BLOCK_WINDOW  = 2'd2;
  localparam logic [1:0] CFG_MAX_ATTEMPTS  = 2'd3;

  localparam logic [31:0] RST_BASE_ADDRESS = 32'd0;
  localparam logic [15:0] RST_START_WINDOW = 16'd10000;
  localparam logic [15:0] RST_BLOCK_WINDOW = 16'd1000;
  localparam logic [3:0]  RST_MAX_ATTEMPTS = 4'd10;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_BYTE     = 3'd1,
    OP_TICK     = 3'd2,
    OP_FLASH    = 3'd3,
    OP_LINE_ERR = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_PROG = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_REPLY  = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_PROG   = 2'd2,
    KIND_FINISH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_COMMS    = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_PROGFAIL = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] rx_byte;
    logic       flash_ok;
  } in_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  reply_byte;
    logic [7:0]  data_byte;
    logic [6:0]  data_offset;
    logic [31:0] write_address;
    status_t     final_status;
    logic        last;
  } out_t;

endpackage

FILE: rtl/core/xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// XMODEM receiver, 128-byte blocks with arithmetic checksum, event driven.
// ----------------------------------------------------------------------------
// Takes one event per transfer on the input channel (start, received byte,
// tick, flash done, line error) and updates the protocol state in the same
// cycle; the results an event causes (none to three) go into a four-entry
// result queue that drives the output channel, one result per cycle while
// out_stall is low. An event is accepted every cycle as long as at most one
// result waits in the queue, so events that cause a single result stream at
// one per cycle unless the output stalls; an event that causes two or three
// results holds the input off while the queue drains. Configuration writes
// take effect on the next cycle.
module xmodem_checksum_receiver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  xmr_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xmr_pkg::out_t      out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  // configuration
  logic [31:0] base_address_r;
  logic [15:0] start_window_r;
  logic [15:0] block_window_r;
  logic [3:0]  max_attempts_r;

  // protocol state
  xmr_pkg::phase_t         phase_r, phase_nxt;
  logic                    aff_r, aff_nxt;
  logic [3:0]              attempts_r, attempts_nxt;
  logic [15:0]             window_r, window_nxt;
  logic [xmr_pkg::FP_W-1:0] fpos_r, fpos_nxt;
  logic [7:0]              seen_r, seen_nxt;
  logic                    hgood_r, hgood_nxt;
  logic [7:0]              sum_r, sum_nxt;
  logic [7:0]              exp_blk_r, exp_blk_nxt;
  logic [31:0]             next_addr_r, next_addr_nxt;

  // result queue
  xmr_pkg::out_t              slot_r [xmr_pkg::QUEUE_DEPTH];
  xmr_pkg::out_t              slot_nxt [xmr_pkg::QUEUE_DEPTH];
  logic [xmr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, base_cnt;

  xmr_pkg::out_t res [3];
  logic [1:0]    res_n;
  logic [7:0]    prev_blk;
  logic          frame_good;
  logic          acc, pop;

  function automatic xmr_pkg::out_t mk(xmr_pkg::kind_t kind, logic [7:0] reply,
                                       logic [7:0] data, logic [6:0] off,
                                       logic [31:0] addr, xmr_pkg::status_t st);
    xmr_pkg::out_t r;
    r.result_kind   = kind;
    r.reply_byte    = reply;
    r.data_byte     = data;
    r.data_offset   = off;
    r.write_address = addr;
    r.final_status  = st;
    r.last          = 1'b0;
    return r;
  endfunction

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[0];
  assign in_stall  = (cnt_r > xmr_pkg::CNT_W'(1));
  assign acc       = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign base_cnt  = cnt_r - xmr_pkg::CNT_W'(pop);
  assign prev_blk  = exp_blk_r - 8'd1;
  assign frame_good = hgood_r && (in_data.rx_byte == sum_r);

  // event processing
  always_comb begin
    phase_nxt     = phase_r;
    aff_nxt       = aff_r;
    attempts_nxt  = attempts_r;
    window_nxt    = window_r;
    fpos_nxt      = fpos_r;
    seen_nxt      = seen_r;
    hgood_nxt     = hgood_r;
    sum_nxt       = sum_r;
    exp_blk_nxt   = exp_blk_r;
    next_addr_nxt = next_addr_r;
    res_n         = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end

    if (in_data.opcode == xmr_pkg::OP_START) begin
      exp_blk_nxt   = 8'd1;
      next_addr_nxt = base_address_r;
      aff_nxt       = 1'b1;
      fpos_nxt      = '0;
      sum_nxt       = '0;
      hgood_nxt     = 1'b0;
      seen_nxt      = '0;
      attempts_nxt  = max_attempts_r;
      window_nxt    = start_window_r;
      phase_nxt     = xmr_pkg::PH_RECV;
      res[0] = mk(xmr_pkg::KIND_REPLY, xmr_pkg::CH_NAK, '0, '0, '0, xmr_pkg::ST_OK);
      res_n  = 2'd1;
    end else if (phase_r == xmr_pkg::PH_RECV) begin
      case (in_data.opcode)
        xmr_pkg::OP_BYTE: begin
          if (fpos_r == '0) begin
            if (in_data.rx_byte == xmr_pkg::CH_EOT) begin
              aff_nxt   = 1'b0;
              phase_nxt = xmr_pkg::PH_DONE;
              res[0] = mk(xmr_pkg::KIND_REPLY, xmr_pkg::CH_ACK, '0, '0, '0,
                          xmr_pkg::ST_OK);
              res[1] = mk(xmr_pkg::KIND_FINISH, '0, '0, '0, '0, xmr_pkg::ST_OK);
              res_n  = 2'd2;
            end else begin
              hgood_nxt = (in_data.rx_byte == xmr_pkg::CH_SOH);
              fpos_nxt  = xmr_pkg::FP_W'(1);
            end
          end else if (fpos_r == xmr_pkg::FP_W'(1)) begin
            seen_nxt = in_data.rx_byte;
            if (in_data.rx_byte != exp_blk_r && in_data.rx_byte != prev_blk) begin
              hgood_nxt = 1'b0;
            end
            fpos_nxt = xmr_pkg::FP_W'(2);
          end else if (fpos_r == xmr_pkg::FP_W'(2)) begin
            if (({1'b0, in_data.rx_byte} + {1'b0, seen_r}) != 9'd255) begin
              hgood_nxt = 1'b0;
            end
            fpos_nxt = xmr_pkg::FP_W'(3);
          end else if (fpos_r < xmr_pkg::FP_W'(xmr_pkg::BLOCK_BYTES + 3)) begin
            logic [xmr_pkg::FP_W-1:0] off;
            off      = fpos_r - xmr_pkg::FP_W'(3);
            sum_nxt  = sum_r + in_data.rx_byte;
            fpos_nxt = fpos_r + xmr_pkg::FP_W'(1);
            res[0] = mk(xmr_pkg::KIND_DATA, '0, in_data.rx_byte, off[6:0], '0,
                        xmr_pkg::ST_OK);
            res_n  = 2'd1;
          end else begin
            // checksum byte: close the frame and open the next window
            fpos_nxt     = '0;
            sum_nxt      = '0;
            hgood_nxt    = 1'b0;
            seen_nxt     = '0;
            aff_nxt      = 1'b0;
            attempts_nxt = max_attempts_r;
            window_nxt   = block_window_r;
            res_n        = 2'd1;
            if (!frame_good) begin
              res[0] = mk(xmr_pkg::KIND_REPLY, xmr_pkg::CH_NAK, '0, '0, '0,
                          xmr_pkg::ST_OK);
            end else if (seen_r == exp_blk_r) begin
              res[0] = mk(xmr_pkg::KIND_PROG, '0, '0, '0, next_addr_r,
                          xmr_pkg::ST_OK);
              phase_nxt = xmr_pkg::PH_PROG;
            end else begin
              res[0] = mk(xmr_pkg::KIND_REPLY, xmr_pkg::CH_ACK, '0, '0, '0,
                          xmr_pkg::ST_OK);
            end
          end
        end
        xmr_pkg::OP_TICK: begin
          if (window_r > 16'd1) begin
            window_nxt = window_r - 16'd1;
          end else begin
            // window over: drop the partial frame
            fpos_nxt  = '0;
            sum_nxt   = '0;
            hgood_nxt = 1'b0;
            seen_nxt  = '0;
            if (attempts_r <= 4'd1) begin
              attempts_nxt = '0;
              window_nxt   = '0;
              phase_nxt    = xmr_pkg::PH_DONE;
              res[0] = mk(xmr_pkg::KIND_FINISH, '0, '0, '0, '0,
                          xmr_pkg::ST_TIMEOUT);
              res_n  = 2'd1;
            end else begin
              attempts_nxt = attempts_r - 4'd1;
              if (aff_r) begin
                window_nxt = start_window_r;
                res[0] = mk(xmr_pkg::KIND_REPLY, xmr_pkg::CH_NAK, '0, '0, '0,
                            xmr_pkg::ST_OK);
                res_n  = 2'd1;
              end else begin
                window_nxt = block_window_r;
              end
            end
          end
        end
        xmr_pkg::OP_LINE_ERR: begin
          fpos_nxt  = '0;
          sum_nxt   = '0;
          hgood_nxt = 1'b0;
          seen_nxt  = '0;
          phase_nxt = xmr_pkg::PH_DONE;
          res[0] = mk(xmr_pkg::KIND_FINISH, '0, '0, '0, '0, xmr_pkg::ST_COMMS);
          res_n  = 2'd1;
        end
        default: begin
        end
      endcase
    end else if (phase_r == xmr_pkg::PH_PROG && in_data.opcode == xmr_pkg::OP_FLASH) begin
      if (in_data.flash_ok) begin
        next_addr_nxt = next_addr_r + 32'(xmr_pkg::BLOCK_BYTES);
        exp_blk_nxt   = exp_blk_r + 8'd1;
        attempts_nxt  = max_attempts_r;
        window_nxt    = aff_r ? start_window_r : block_window_r;
        phase_nxt     = xmr_pkg::PH_RECV;
        res[0] = mk(xmr_pkg::KIND_REPLY, xmr_pkg::CH_ACK, '0, '0, '0, xmr_pkg::ST_OK);
        res_n  = 2'd1;
      end else begin
        phase_nxt = xmr_pkg::PH_DONE;
        res[0] = mk(xmr_pkg::KIND_REPLY, xmr_pkg::CH_NAK, '0, '0, '0, xmr_pkg::ST_OK);
        res[1] = mk(xmr_pkg::KIND_REPLY, xmr_pkg::CH_CAN, '0, '0, '0, xmr_pkg::ST_OK);
        res[2] = mk(xmr_pkg::KIND_FINISH, '0, '0, '0, '0, xmr_pkg::ST_PROGFAIL);
        res_n  = 2'd3;
      end
    end

    // mark the final result of this event
    for (int k = 0; k < 3; k++) begin
      if (2'(k + 1) == res_n) begin
        res[k].last = 1'b1;
      end
    end
  end

  // result queue: shift out at the head, append behind what remains
  always_comb begin
    for (int i = 0; i < xmr_pkg::QUEUE_DEPTH; i++) begin
      if (pop && i < xmr_pkg::QUEUE_DEPTH - 1) begin
        slot_nxt[i] = slot_r[i + 1];
      end else begin
        slot_nxt[i] = slot_r[i];
      end
      for (int k = 0; k < 3; k++) begin
        if (acc && (2'(k) < res_n) &&
            (xmr_pkg::CNT_W'(i) == base_cnt + xmr_pkg::CNT_W'(k))) begin
          slot_nxt[i] = res[k];
        end
      end
    end
    cnt_nxt = base_cnt + (acc ? xmr_pkg::CNT_W'(res_n) : '0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < xmr_pkg::QUEUE_DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r          <= '0;
      base_address_r <= xmr_pkg::RST_BASE_ADDRESS;
      start_window_r <= xmr_pkg::RST_START_WINDOW;
      block_window_r <= xmr_pkg::RST_BLOCK_WINDOW;
      max_attempts_r <= xmr_pkg::RST_MAX_ATTEMPTS;
      phase_r        <= xmr_pkg::PH_IDLE;
      aff_r          <= 1'b0;
      attempts_r     <= '0;
      window_r       <= '0;
      fpos_r         <= '0;
      seen_r         <= '0;
      hgood_r        <= 1'b0;
      sum_r          <= '0;
      exp_blk_r      <= 8'd1;
      next_addr_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          xmr_pkg::CFG_BASE_ADDRESS: base_address_r <= cfg_wdata;
          xmr_pkg::CFG_START_WINDOW: start_window_r <= cfg_wdata[15:0];
          xmr_pkg::CFG_BLOCK_WINDOW: block_window_r <= cfg_wdata[15:0];
          xmr_pkg::CFG_MAX_ATTEMPTS: max_attempts_r <= cfg_wdata[3:0];
          default: begin
          end
        endcase
      end
      if (acc) begin
        phase_r     <= phase_nxt;
        aff_r       <= aff_nxt;
        attempts_r  <= attempts_nxt;
        window_r    <= window_nxt;
        fpos_r      <= fpos_nxt;
        seen_r      <= seen_nxt;
        hgood_r     <= hgood_nxt;
        sum_r       <= sum_nxt;
        exp_blk_r   <= exp_blk_nxt;
        next_addr_r <= next_addr_nxt;
      end
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= xmr_pkg::CNT_W'(xmr_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_prog_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == xmr_pkg::PH_PROG |-> fpos_r == '0)
    else $error("partial frame held while programming");

  a_fpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    fpos_r <= xmr_pkg::FP_W'(xmr_pkg::BLOCK_BYTES + 3))
    else $error("frame position out of range");

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res_n != 2'd0 |=> out_valid)
    else $error("accepted event lost its results");

endmodule

FILE: test/xmodem_checksum_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_test
// Self-checking bench for the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
// A queue-fed driver presents receiver events: starts, frame bytes, ticks,
// flash completions and line errors. Each accepted event runs through a
// behavioral copy of the receiver, which queues the replies, staged bytes,
// program requests and finish codes it should cause. The monitor checks every
// result against that queue. Both channels idle in random bursts but for the
// last part. Between sessions the bench drains and rewrites the registers.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_test;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

  typedef enum int {FL_NONE, FL_SUM, FL_CPL, FL_SOH, FL_TICKS} flaw_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  xmr_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  xmr_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = '0;
  logic [31:0]   cfg_wdata = '0;

  xmodem_checksum_receiver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copy
  logic [31:0] reg_base      = xmr_pkg::RST_BASE_ADDRESS;
  logic [15:0] reg_start_win = xmr_pkg::RST_START_WINDOW;
  logic [15:0] reg_block_win = xmr_pkg::RST_BLOCK_WINDOW;
  logic [3:0]  reg_max_tries = xmr_pkg::RST_MAX_ATTEMPTS;

  // protocol state copy
  xmr_pkg::phase_t rx_phase  = xmr_pkg::PH_IDLE;
  bit          first_pending = 1'b0;
  logic [3:0]  tries_left    = '0;
  logic [15:0] ticks_left    = '0;
  logic [7:0]  frame_pos     = '0;
  logic [7:0]  blk_seen      = '0;
  bit          hdr_ok        = 1'b0;
  logic [7:0]  csum          = '0;
  logic [7:0]  want_blk      = 8'd1;
  logic [31:0] flash_addr    = '0;

  xmr_pkg::in_t  event_q[$];
  xmr_pkg::out_t due_results[$];
  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned idle_cycles = 0;
  int          errors     = 0;
  bit          quiet      = 1'b0;
  int          gap_left   = 0;
  int          stall_left = 0;

  function automatic void drop_frame();
    frame_pos = '0;
    csum      = '0;
    hdr_ok    = 1'b0;
    blk_seen  = '0;
  endfunction

  function automatic void reload_window();
    tries_left = reg_max_tries;
    ticks_left = first_pending ? reg_start_win : reg_block_win;
  endfunction

  function automatic xmr_pkg::out_t make_result(xmr_pkg::kind_t k, logic [7:0] rb,
                                                logic [7:0] db, logic [6:0] off,
                                                logic [31:0] addr,
                                                xmr_pkg::status_t st);
    xmr_pkg::out_t r;
    r.result_kind   = k;
    r.reply_byte    = rb;
    r.data_byte     = db;
    r.data_offset   = off;
    r.write_address = addr;
    r.final_status  = st;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic xmr_pkg::out_t reply(logic [7:0] rb);
    return make_result(xmr_pkg::KIND_REPLY, rb, 8'd0, 7'd0, 32'd0, xmr_pkg::ST_OK);
  endfunction

  function automatic xmr_pkg::out_t finish(xmr_pkg::status_t st);
    return make_result(xmr_pkg::KIND_FINISH, 8'd0, 8'd0, 7'd0, 32'd0, st);
  endfunction

  // Apply one accepted event to the state copy and queue what it causes.
  function automatic void advance_receiver(xmr_pkg::in_t ev_in);
    xmr_pkg::out_t res[$];
    logic [7:0] b;
    logic [7:0] prev;
    logic [8:0] hsum;
    logic [7:0] seen;
    bit         good;
    b    = ev_in.rx_byte;
    prev = want_blk - 8'd1;
    if (ev_in.opcode == xmr_pkg::OP_START) begin
      want_blk      = 8'd1;
      flash_addr    = reg_base;
      first_pending = 1'b1;
      drop_frame();
      reload_window();
      rx_phase = xmr_pkg::PH_RECV;
      res.push_back(reply(xmr_pkg::CH_NAK));
    end else if (rx_phase == xmr_pkg::PH_RECV) begin
      case (ev_in.opcode)
        xmr_pkg::OP_BYTE: begin
          if (frame_pos == 8'd0) begin
            if (b == xmr_pkg::CH_EOT) begin
              first_pending = 1'b0;
              res.push_back(reply(xmr_pkg::CH_ACK));
              res.push_back(finish(xmr_pkg::ST_OK));
              rx_phase = xmr_pkg::PH_DONE;
            end else begin
              hdr_ok    = (b == xmr_pkg::CH_SOH);
              frame_pos = 8'd1;
            end
          end else if (frame_pos == 8'd1) begin
            blk_seen = b;
            if (b != want_blk && b != prev) hdr_ok = 1'b0;
            frame_pos = 8'd2;
          end else if (frame_pos == 8'd2) begin
            hsum = {1'b0, b} + {1'b0, blk_seen};
            if (hsum != 9'd255) hdr_ok = 1'b0;
            frame_pos = 8'd3;
          end else if (frame_pos < 8'(3 + xmr_pkg::BLOCK_BYTES)) begin
            // stage the byte even when the header is already known bad
            csum = csum + b;
            res.push_back(make_result(xmr_pkg::KIND_DATA, 8'd0, b, 7'(frame_pos - 8'd3),
                                      32'd0, xmr_pkg::ST_OK));
            frame_pos = frame_pos + 8'd1;
          end else begin
            good = hdr_ok && (b == csum);
            seen = blk_seen;
            drop_frame();
            first_pending = 1'b0;
            reload_window();
            if (!good) begin
              res.push_back(reply(xmr_pkg::CH_NAK));
            end else if (seen == want_blk) begin
              res.push_back(make_result(xmr_pkg::KIND_PROG, 8'd0, 8'd0, 7'd0, flash_addr,
                                        xmr_pkg::ST_OK));
              rx_phase = xmr_pkg::PH_PROG;
            end else begin
              res.push_back(reply(xmr_pkg::CH_ACK));
            end
          end
        end
        xmr_pkg::OP_TICK: begin
          if (ticks_left > 16'd1) begin
            ticks_left = ticks_left - 16'd1;
          end else begin
            drop_frame();
            if (tries_left <= 4'd1) begin
              tries_left = '0;
              ticks_left = '0;
              rx_phase   = xmr_pkg::PH_DONE;
              res.push_back(finish(xmr_pkg::ST_TIMEOUT));
            end else begin
              tries_left = tries_left - 4'd1;
              if (first_pending) begin
                ticks_left = reg_start_win;
                res.push_back(reply(xmr_pkg::CH_NAK));
              end else begin
                ticks_left = reg_block_win;
              end
            end
          end
        end
        xmr_pkg::OP_LINE_ERR: begin
          drop_frame();
          rx_phase = xmr_pkg::PH_DONE;
          res.push_back(finish(xmr_pkg::ST_COMMS));
        end
        default: ;
      endcase
    end else if (rx_phase == xmr_pkg::PH_PROG && ev_in.opcode == xmr_pkg::OP_FLASH) begin
      if (ev_in.flash_ok) begin
        flash_addr = flash_addr + 32'(xmr_pkg::BLOCK_BYTES);
        want_blk   = want_blk + 8'd1;
        reload_window();
        rx_phase = xmr_pkg::PH_RECV;
        res.push_back(reply(xmr_pkg::CH_ACK));
      end else begin
        rx_phase = xmr_pkg::PH_DONE;
        res.push_back(reply(xmr_pkg::CH_NAK));
        res.push_back(reply(xmr_pkg::CH_CAN));
        res.push_back(finish(xmr_pkg::ST_PROGFAIL));
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) due_results.push_back(res[i]);
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic void send(logic [2:0] op, logic [7:0] b, logic ok);
    event_q.push_back(xmr_pkg::in_t'{opcode: xmr_pkg::opcode_t'(op), rx_byte: b,
                                     flash_ok: ok});
    n_queued++;
  endfunction

  // event whose unused fields carry random bits
  function automatic void ev(logic [2:0] op);
    send(op, 8'($urandom), 1'($urandom));
  endfunction

  function automatic void send_frame(logic [7:0] blk, flaw_t flaw);
    logic [7:0] sum;
    logic [7:0] d;
    logic [7:0] lead;
    int         i;
    sum  = '0;
    lead = xmr_pkg::CH_SOH;
    if (flaw == FL_SOH) begin
      do lead = 8'($urandom); while (lead == xmr_pkg::CH_SOH || lead == xmr_pkg::CH_EOT);
    end
    send(xmr_pkg::OP_BYTE, lead, 1'($urandom));
    send(xmr_pkg::OP_BYTE, blk, 1'($urandom));
    if (flaw == FL_CPL) begin
      send(xmr_pkg::OP_BYTE, ~blk ^ (8'd1 << $urandom_range(0, 7)), 1'($urandom));
    end else begin
      send(xmr_pkg::OP_BYTE, ~blk, 1'($urandom));
    end
    for (i = 0; i < xmr_pkg::BLOCK_BYTES; i++) begin
      d   = 8'($urandom);
      sum = sum + d;
      send(xmr_pkg::OP_BYTE, d, 1'($urandom));
      if (flaw == FL_TICKS && $urandom_range(0, 31) == 0) ev(xmr_pkg::OP_TICK);
    end
    if (flaw == FL_SUM) begin
      send(xmr_pkg::OP_BYTE, sum + 8'($urandom_range(1, 255)), 1'($urandom));
    end else begin
      send(xmr_pkg::OP_BYTE, sum, 1'($urandom));
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || due_results.size() != 0);
    // let any event with no result settle before touching registers
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      xmr_pkg::CFG_BASE_ADDRESS: reg_base      = val;
      xmr_pkg::CFG_START_WINDOW: reg_start_win = val[15:0];
      xmr_pkg::CFG_BLOCK_WINDOW: reg_block_win = val[15:0];
      xmr_pkg::CFG_MAX_ATTEMPTS: reg_max_tries = val[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_config(bit tick_heavy);
    logic [31:0] base;
    case ($urandom_range(0, 3))
      0:       base = 32'h0000_0000;
      1:       base = 32'hFFFF_FFFF;
      2:       base = 32'hFFFF_FF80;
      default: base = $urandom;
    endcase
    cfg_write(xmr_pkg::CFG_BASE_ADDRESS, base);
    if (tick_heavy) begin
      cfg_write(xmr_pkg::CFG_START_WINDOW, $urandom_range(0, 5));
      cfg_write(xmr_pkg::CFG_BLOCK_WINDOW, $urandom_range(0, 5));
      cfg_write(xmr_pkg::CFG_MAX_ATTEMPTS, $urandom_range(0, 15));
    end else begin
      // windows wide enough that scattered ticks never end one mid-frame
      cfg_write(xmr_pkg::CFG_START_WINDOW, ($urandom_range(0, 3) == 0) ? 32'hFFFF :
                                           $urandom_range(200, 65535));
      cfg_write(xmr_pkg::CFG_BLOCK_WINDOW, ($urandom_range(0, 3) == 0) ? 32'hFFFF :
                                           $urandom_range(200, 65535));
      cfg_write(xmr_pkg::CFG_MAX_ATTEMPTS, $urandom_range(1, 15));
    end
  endtask

  task automatic frame_session(int n_frames);
    logic [7:0] blk;
    int         k;
    bit         ok;
    blk = 8'd1;
    ev(xmr_pkg::OP_START);
    for (k = 0; k < n_frames; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          send_frame(blk, FL_NONE);
          if ($urandom_range(0, 3) == 0) ev(xmr_pkg::OP_TICK);
          ok = ($urandom_range(0, 7) != 0);
          send(xmr_pkg::OP_FLASH, 8'($urandom), ok);
          if (!ok) break;
          blk = blk + 8'd1;
        end
        5: send_frame(blk - 8'd1, FL_NONE);
        6: send_frame(blk, flaw_t'($urandom_range(FL_SUM, FL_SOH)));
        7: send_frame(blk + 8'($urandom_range(1, 254)), FL_NONE);
        8: begin
          send_frame(blk, FL_TICKS);
          send(xmr_pkg::OP_FLASH, 8'($urandom), 1'b1);
          blk = blk + 8'd1;
        end
        default: begin
          // line noise, then restart from block one
          repeat ($urandom_range(1, 6)) begin
            ev(3'($urandom_range(xmr_pkg::OP_BYTE, OP_UNUSED_HI)));
          end
          ev(xmr_pkg::OP_START);
          blk = 8'd1;
        end
      endcase
    end
    case ($urandom_range(0, 3))
      0:       ev(xmr_pkg::OP_LINE_ERR);
      1:       ;
      default: send(xmr_pkg::OP_BYTE, xmr_pkg::CH_EOT, 1'($urandom));
    endcase
  endtask

  task automatic tick_session();
    ev(xmr_pkg::OP_START);
    repeat ($urandom_range(0, 4)) ev(xmr_pkg::OP_TICK);
    repeat ($urandom_range(1, 6)) send(xmr_pkg::OP_BYTE, 8'($urandom), 1'($urandom));
    repeat (int'(reg_start_win) + 2) ev(xmr_pkg::OP_TICK);
    send_frame(8'd1, FL_NONE);
    send(xmr_pkg::OP_FLASH, 8'($urandom), 1'b1);
    repeat ((int'(reg_max_tries) + 1) * (int'(reg_block_win) + 1) + 2) ev(xmr_pkg::OP_TICK);
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    logic         nv;
    xmr_pkg::in_t nd;
    nv = in_valid;
    nd = in_data;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_receiver(in_data);
        n_accepted++;
        nv = 1'b0;
      end
      // hold a stalled transfer, otherwise maybe idle, otherwise advance
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          gap_left = $urandom_range(0, 11);
        end else if (event_q.size() > 0) begin
          nd = event_q.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // ---------------- monitor ----------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    xmr_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_data.result_kind));
          check_field("reply_byte", 32'(want.reply_byte), 32'(out_data.reply_byte));
          check_field("data_byte", 32'(want.data_byte), 32'(out_data.data_byte));
          check_field("data_offset", 32'(want.data_offset), 32'(out_data.data_offset));
          check_field("write_address", want.write_address, out_data.write_address);
          check_field("final_status", 32'(want.final_status),
                      32'(out_data.final_status));
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // events ignored while idle, field extremes on the unused codes
    ev(xmr_pkg::OP_TICK);
    send(xmr_pkg::OP_BYTE, 8'hFF, 1'b1);
    send(xmr_pkg::OP_FLASH, 8'h00, 1'b0);
    ev(xmr_pkg::OP_LINE_ERR);
    send(OP_UNUSED_LO, 8'hFF, 1'b1);
    send(OP_UNUSED_MID, 8'h00, 1'b0);
    send(OP_UNUSED_HI, 8'hA5, 1'b1);
    // EOT right after start, then ignored events once finished
    ev(xmr_pkg::OP_START);
    send(xmr_pkg::OP_BYTE, xmr_pkg::CH_EOT, 1'b0);
    send(xmr_pkg::OP_BYTE, 8'h00, 1'b0);
    ev(xmr_pkg::OP_TICK);
    // flash done ignored while receiving, line error ends the transfer
    ev(xmr_pkg::OP_START);
    send(xmr_pkg::OP_FLASH, 8'h00, 1'b1);
    ev(xmr_pkg::OP_LINE_ERR);
    // frame led by a non-SOH byte, restart mid-frame
    ev(xmr_pkg::OP_START);
    send(xmr_pkg::OP_BYTE, 8'hFF, 1'b0);
    send(xmr_pkg::OP_BYTE, 8'h00, 1'b1);
    ev(xmr_pkg::OP_START);
    send(xmr_pkg::OP_BYTE, xmr_pkg::CH_SOH, 1'b0);
    ev(xmr_pkg::OP_LINE_ERR);
    wait_drained();

    // zero windows and zero attempts: first tick times out
    cfg_write(xmr_pkg::CFG_START_WINDOW, 32'd0);
    cfg_write(xmr_pkg::CFG_BLOCK_WINDOW, 32'd0);
    cfg_write(xmr_pkg::CFG_MAX_ATTEMPTS, 32'd0);
    ev(xmr_pkg::OP_START);
    ev(xmr_pkg::OP_TICK);
    wait_drained();

    // NAK repeated on each timed-out window before the first frame, until the attempts run out
    cfg_write(xmr_pkg::CFG_MAX_ATTEMPTS, 32'd3);
    cfg_write(xmr_pkg::CFG_START_WINDOW, 32'd1);
    ev(xmr_pkg::OP_START);
    repeat (3) ev(xmr_pkg::OP_TICK);
    wait_drained();

    // one full block with short windows around it
    random_config(1'b1);
    tick_session();
    wait_drained();

    // last part: no idling on either side
    quiet = 1'b1;
    random_config(1'b0);
    frame_session(0);
    wait_drained();

    repeat (20) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/xmr_pkg.sv
rtl/core/xmodem_checksum_receiver.sv
test/xmodem_checksum_receiver_test.sv
